// ----- src/qpv_pkg.sv -----
// ----------------------------------------------------------------------------
// qpv_pkg
// Shared types and constants of the quadratic peak vertex fit.
// ----------------------------------------------------------------------------
`default_nettype none

package qpv_pkg;

    localparam int MAX_POINTS    = 64;
    localparam int POSITION_BITS = 12;
    localparam int FRACTION_BITS = 8;

    localparam int POS_W   = 12;
    localparam int AMP_W   = 16;
    localparam int VERT_W  = 24;
    localparam int STAT_W  = 2;
    localparam int COUNT_W = 7;
    localparam int SX_W    = 18;
    localparam int SX2_W   = 30;
    localparam int SX3_W   = 42;
    localparam int SX4_W   = 54;
    localparam int SY_W    = 22;
    localparam int SXY_W   = 34;
    localparam int SX2Y_W  = 46;
    localparam int WIDE_W  = 128;
    localparam int LIMB_W  = 32;
    localparam int MOP_W   = 33;
    localparam int PROD_W  = 66;
    localparam int NTERMS  = 12;

    localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
    localparam logic [STAT_W-1:0] ST_DEGEN = 2'd1;
    localparam logic [STAT_W-1:0] ST_SAT   = 2'd2;

    localparam logic [LIMB_W-1:0] VMAX_POS = 32'd8388607;
    localparam logic [LIMB_W-1:0] VMAX_NEG = 32'd8388608;

    typedef logic [WIDE_W-1:0] wide_t;
    typedef logic signed [MOP_W-1:0] mop_t;
    typedef logic signed [PROD_W-1:0] prod_t;

    typedef struct packed {
        logic [POS_W-1:0]        peak_position;
        logic signed [AMP_W-1:0] peak_amplitude;
        logic                    last_point;
    } in_word_t;

    typedef struct packed {
        logic signed [VERT_W-1:0] vertex_position;
        logic [STAT_W-1:0]        fit_status;
    } out_word_t;

    typedef enum logic [2:0] {
        SRC_N, SRC_SX, SRC_SX2, SRC_SX3, SRC_SX4, SRC_SY, SRC_SXY, SRC_SX2Y
    } src_t;

    localparam src_t TERM_A [NTERMS] = '{SRC_N, SRC_N, SRC_SY, SRC_SY, SRC_SX2, SRC_SX2,
                                         SRC_N, SRC_N, SRC_SX, SRC_SX, SRC_SY, SRC_SY};
    localparam src_t TERM_B [NTERMS] = '{SRC_SXY, SRC_SX3, SRC_SX, SRC_SX3, SRC_SX, SRC_SXY,
                                         SRC_SX2, SRC_SXY, SRC_SX, SRC_SXY, SRC_SX, SRC_SX2};
    localparam src_t TERM_C [NTERMS] = '{SRC_SX4, SRC_SX2Y, SRC_SX4, SRC_SX2, SRC_SX2Y,
                                         SRC_SX2, SRC_SX2Y, SRC_SX3, SRC_SX2Y, SRC_SX2,
                                         SRC_SX3, SRC_SX2};
    localparam logic TERM_NEG [NTERMS] = '{1'b0, 1'b1, 1'b1, 1'b0, 1'b0, 1'b1,
                                           1'b0, 1'b1, 1'b1, 1'b0, 1'b0, 1'b1};

endpackage

`default_nettype wire

// ----- src/qpv_mul.sv -----
// ----------------------------------------------------------------------------
// qpv_mul
// Shared signed 33 by 33 multiplier with a registered product.
// ----------------------------------------------------------------------------
`default_nettype none

module qpv_mul (
    input  wire logic          aclk,
    input  wire qpv_pkg::mop_t a,
    input  wire qpv_pkg::mop_t b,
    output qpv_pkg::prod_t     p
);

    qpv_pkg::prod_t p_reg;

    always_ff @(posedge aclk) begin
        p_reg <= a * b;
    end

    assign p = p_reg;

endmodule

`default_nettype wire

// ----- src/qpv_div.sv -----
// ----------------------------------------------------------------------------
// qpv_div
// Restoring unsigned 128-bit divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module qpv_div (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           start,
    input  wire qpv_pkg::wide_t num,
    input  wire qpv_pkg::wide_t den,
    output logic                done,
    output qpv_pkg::wide_t      quo
);

    qpv_pkg::wide_t num_reg;
    qpv_pkg::wide_t den_reg;
    qpv_pkg::wide_t rem_reg;
    qpv_pkg::wide_t quo_reg;
    logic [6:0]     cnt_reg;
    logic           busy_reg;
    logic           done_reg;
    qpv_pkg::wide_t rem_sh;

    assign rem_sh = {rem_reg[qpv_pkg::WIDE_W-2:0], num_reg[qpv_pkg::WIDE_W-1]};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '1;
                num_reg  <= num;
                den_reg  <= den;
                rem_reg  <= '0;
                quo_reg  <= '0;
            end else if (busy_reg) begin
                num_reg <= {num_reg[qpv_pkg::WIDE_W-2:0], 1'b0};
                if (rem_sh >= den_reg) begin
                    rem_reg <= rem_sh - den_reg;
                    quo_reg <= {quo_reg[qpv_pkg::WIDE_W-2:0], 1'b1};
                end else begin
                    rem_reg <= rem_sh;
                    quo_reg <= {quo_reg[qpv_pkg::WIDE_W-2:0], 1'b0};
                end
                cnt_reg <= cnt_reg - 7'd1;
                if (cnt_reg == 7'd0) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign done = done_reg;
    assign quo  = quo_reg;

endmodule

`default_nettype wire

// ----- src/quadratic_peak_vertex_fit.sv -----
// ----------------------------------------------------------------------------
// quadratic_peak_vertex_fit
// Least squares parabola fit over a run of peak points, vertex output.
//
//   Channel   Ports          Word         Direction
//   input     s_valid/ready  in_word_t    peak point in
//   result    m_valid/ready  out_word_t   vertex and status out
//
// For each point, power sums are built on the shared multiplier.
// A last point adds the solve: 12 terms of two 128-bit products, each built
// from 32-bit limb products, then the S_ABS and S_NUM setup states and a
// 128-bit divide, watched in S_DIV until it finishes.
// Reset clears all sums and the output valid flag; no clearing pass.
// A finished result waits in the output register while new points are taken.
// ----------------------------------------------------------------------------
`default_nettype none

module quadratic_peak_vertex_fit (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire qpv_pkg::in_word_t  s_data,
    output logic                    m_valid,
    input  wire logic               m_ready,
    output qpv_pkg::out_word_t      m_data
);

    typedef enum logic [3:0] {
        S_IDLE, S_PT0, S_PT1, S_PT2, S_PT3, S_PT4, S_PT5,
        S_SOLVE, S_MUL, S_TERM, S_ABS, S_NUM, S_DIV, S_DONE
    } state_t;

    state_t state_reg;

    logic [qpv_pkg::COUNT_W-1:0]      count_reg;
    logic [qpv_pkg::SX_W-1:0]         sx_reg;
    logic [qpv_pkg::SX2_W-1:0]        sx2_reg;
    logic [qpv_pkg::SX3_W-1:0]        sx3_reg;
    logic [qpv_pkg::SX4_W-1:0]        sx4_reg;
    logic signed [qpv_pkg::SY_W-1:0]  sy_reg;
    logic signed [qpv_pkg::SXY_W-1:0] sxy_reg;
    logic signed [qpv_pkg::SX2Y_W-1:0] sx2y_reg;

    logic [qpv_pkg::POS_W-1:0]        x_reg;
    logic signed [qpv_pkg::AMP_W-1:0] y_reg;
    logic [2*qpv_pkg::POS_W-1:0]      x2_reg;
    logic                             last_reg;

    qpv_pkg::wide_t opx_reg, opy_reg, macc_reg, p_reg, db_reg, dc_reg;
    logic [4:0]     k_reg;
    logic [3:0]     term_reg;
    logic           phase_reg;
    logic           neg_reg;

    logic                              m_valid_reg;
    logic signed [qpv_pkg::VERT_W-1:0] res_pos_reg, out_pos_reg;
    logic [qpv_pkg::STAT_W-1:0]        res_stat_reg, out_stat_reg;

    qpv_pkg::mop_t  mul_a, mul_b;
    qpv_pkg::prod_t prod;
    logic           div_start, div_done;
    qpv_pkg::wide_t div_num, div_den, div_quo;

    logic [3:0]     kd;
    qpv_pkg::wide_t macc_add;
    qpv_pkg::wide_t p_new;
    qpv_pkg::wide_t lim;
    logic [3:0]     term_nx;

    function automatic qpv_pkg::wide_t src_val(
        input qpv_pkg::src_t s,
        input logic [qpv_pkg::COUNT_W-1:0] n,
        input logic [qpv_pkg::SX_W-1:0] a1,
        input logic [qpv_pkg::SX2_W-1:0] a2,
        input logic [qpv_pkg::SX3_W-1:0] a3,
        input logic [qpv_pkg::SX4_W-1:0] a4,
        input logic [qpv_pkg::SY_W-1:0] b0,
        input logic [qpv_pkg::SXY_W-1:0] b1,
        input logic [qpv_pkg::SX2Y_W-1:0] b2
    );
        qpv_pkg::wide_t v;
        case (s)
            qpv_pkg::SRC_N:    v = qpv_pkg::WIDE_W'(n);
            qpv_pkg::SRC_SX:   v = qpv_pkg::WIDE_W'(a1);
            qpv_pkg::SRC_SX2:  v = qpv_pkg::WIDE_W'(a2);
            qpv_pkg::SRC_SX3:  v = qpv_pkg::WIDE_W'(a3);
            qpv_pkg::SRC_SX4:  v = qpv_pkg::WIDE_W'(a4);
            qpv_pkg::SRC_SY:
                v = {{(qpv_pkg::WIDE_W-qpv_pkg::SY_W){b0[qpv_pkg::SY_W-1]}}, b0};
            qpv_pkg::SRC_SXY:
                v = {{(qpv_pkg::WIDE_W-qpv_pkg::SXY_W){b1[qpv_pkg::SXY_W-1]}}, b1};
            qpv_pkg::SRC_SX2Y:
                v = {{(qpv_pkg::WIDE_W-qpv_pkg::SX2Y_W){b2[qpv_pkg::SX2Y_W-1]}}, b2};
            default: v = '0;
        endcase
        return v;
    endfunction

    assign kd       = k_reg[3:0] - 4'd1;
    assign macc_add = macc_reg + (qpv_pkg::wide_t'(prod[63:0]) <<
                      {5'(kd[3:2]) + 5'(kd[1:0]), 5'b0});
    assign p_new    = qpv_pkg::TERM_NEG[term_reg] ? (p_reg - macc_reg) : (p_reg + macc_reg);
    assign term_nx  = term_reg + 4'd1;
    assign lim      = qpv_pkg::WIDE_W'(neg_reg ? qpv_pkg::VMAX_NEG : qpv_pkg::VMAX_POS);

    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            S_PT0: begin
                mul_a = qpv_pkg::MOP_W'(x_reg);
                mul_b = qpv_pkg::MOP_W'(x_reg);
            end
            S_PT1: begin
                mul_a = qpv_pkg::MOP_W'(prod[2*qpv_pkg::POS_W-1:0]);
                mul_b = qpv_pkg::MOP_W'(x_reg);
            end
            S_PT2: begin
                mul_a = qpv_pkg::MOP_W'(x2_reg);
                mul_b = qpv_pkg::MOP_W'(x2_reg);
            end
            S_PT3: begin
                mul_a = qpv_pkg::MOP_W'(x_reg);
                mul_b = qpv_pkg::MOP_W'(y_reg);
            end
            S_PT4: begin
                mul_a = qpv_pkg::MOP_W'(x2_reg);
                mul_b = qpv_pkg::MOP_W'(y_reg);
            end
            S_MUL: begin
                mul_a = {1'b0, opx_reg[qpv_pkg::LIMB_W*k_reg[3:2] +: qpv_pkg::LIMB_W]};
                mul_b = {1'b0, opy_reg[qpv_pkg::LIMB_W*k_reg[1:0] +: qpv_pkg::LIMB_W]};
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    qpv_mul u_mul (
        .aclk (aclk),
        .a    (mul_a),
        .b    (mul_b),
        .p    (prod)
    );

    assign div_start = (state_reg == S_NUM);
    assign div_num   = (db_reg << (qpv_pkg::FRACTION_BITS + 1)) + (dc_reg << 1);
    assign div_den   = dc_reg << 2;

    qpv_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .num     (div_num),
        .den     (div_den),
        .done    (div_done),
        .quo     (div_quo)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            m_valid_reg <= 1'b0;
            count_reg   <= '0;
            sx_reg      <= '0;
            sx2_reg     <= '0;
            sx3_reg     <= '0;
            sx4_reg     <= '0;
            sy_reg      <= '0;
            sxy_reg     <= '0;
            sx2y_reg    <= '0;
        end else begin
            if (state_reg == S_DONE && (!m_valid_reg || m_ready)) begin
                m_valid_reg <= 1'b1;
            end else if (m_valid_reg && m_ready) begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE: begin
                    if (s_valid) begin
                        x_reg    <= s_data.peak_position[qpv_pkg::POSITION_BITS-1:0];
                        y_reg    <= s_data.peak_amplitude;
                        last_reg <= s_data.last_point;
                        if (count_reg < qpv_pkg::COUNT_W'(qpv_pkg::MAX_POINTS)) begin
                            count_reg <= count_reg + 1'b1;
                            sx_reg    <= sx_reg + qpv_pkg::SX_W'(
                                         s_data.peak_position[qpv_pkg::POSITION_BITS-1:0]);
                            sy_reg    <= sy_reg + qpv_pkg::SY_W'(s_data.peak_amplitude);
                            state_reg <= S_PT0;
                        end else if (s_data.last_point) begin
                            state_reg <= S_SOLVE;
                        end
                    end
                end
                S_PT0: state_reg <= S_PT1;
                S_PT1: begin
                    x2_reg    <= prod[2*qpv_pkg::POS_W-1:0];
                    sx2_reg   <= sx2_reg + qpv_pkg::SX2_W'(prod[2*qpv_pkg::POS_W-1:0]);
                    state_reg <= S_PT2;
                end
                S_PT2: begin
                    sx3_reg   <= sx3_reg + prod[qpv_pkg::SX3_W-1:0];
                    state_reg <= S_PT3;
                end
                S_PT3: begin
                    sx4_reg   <= sx4_reg + prod[qpv_pkg::SX4_W-1:0];
                    state_reg <= S_PT4;
                end
                S_PT4: begin
                    sxy_reg   <= sxy_reg + prod[qpv_pkg::SXY_W-1:0];
                    state_reg <= S_PT5;
                end
                S_PT5: begin
                    sx2y_reg  <= sx2y_reg + prod[qpv_pkg::SX2Y_W-1:0];
                    state_reg <= last_reg ? S_SOLVE : S_IDLE;
                end
                S_SOLVE: begin
                    if (count_reg < qpv_pkg::COUNT_W'(3)) begin
                        res_pos_reg  <= '0;
                        res_stat_reg <= qpv_pkg::ST_DEGEN;
                        state_reg    <= S_DONE;
                    end else begin
                        term_reg  <= '0;
                        phase_reg <= 1'b0;
                        k_reg     <= '0;
                        macc_reg  <= '0;
                        p_reg     <= '0;
                        opx_reg   <= src_val(qpv_pkg::TERM_A[0], count_reg, sx_reg, sx2_reg,
                                             sx3_reg, sx4_reg, sy_reg, sxy_reg, sx2y_reg);
                        opy_reg   <= src_val(qpv_pkg::TERM_B[0], count_reg, sx_reg, sx2_reg,
                                             sx3_reg, sx4_reg, sy_reg, sxy_reg, sx2y_reg);
                        state_reg <= S_MUL;
                    end
                end
                S_MUL: begin
                    k_reg <= k_reg + 5'd1;
                    if (k_reg != 5'd0) begin
                        macc_reg <= macc_add;
                    end
                    if (k_reg == 5'd16) begin
                        state_reg <= S_TERM;
                    end
                end
                S_TERM: begin
                    k_reg    <= '0;
                    macc_reg <= '0;
                    if (!phase_reg) begin
                        phase_reg <= 1'b1;
                        opx_reg   <= macc_reg;
                        opy_reg   <= src_val(qpv_pkg::TERM_C[term_reg], count_reg, sx_reg,
                                             sx2_reg, sx3_reg, sx4_reg, sy_reg, sxy_reg,
                                             sx2y_reg);
                        state_reg <= S_MUL;
                    end else begin
                        phase_reg <= 1'b0;
                        term_reg  <= term_nx;
                        if (term_reg == 4'd5) begin
                            db_reg <= p_new;
                            p_reg  <= '0;
                        end else begin
                            p_reg  <= p_new;
                        end
                        if (term_reg == 4'(qpv_pkg::NTERMS - 1)) begin
                            dc_reg    <= p_new;
                            state_reg <= S_ABS;
                        end else begin
                            opx_reg   <= src_val(qpv_pkg::TERM_A[term_nx], count_reg, sx_reg,
                                                 sx2_reg, sx3_reg, sx4_reg, sy_reg, sxy_reg,
                                                 sx2y_reg);
                            opy_reg   <= src_val(qpv_pkg::TERM_B[term_nx], count_reg, sx_reg,
                                                 sx2_reg, sx3_reg, sx4_reg, sy_reg, sxy_reg,
                                                 sx2y_reg);
                            state_reg <= S_MUL;
                        end
                    end
                end
                S_ABS: begin
                    if (dc_reg == '0) begin
                        res_pos_reg  <= '0;
                        res_stat_reg <= qpv_pkg::ST_DEGEN;
                        state_reg    <= S_DONE;
                    end else begin
                        neg_reg <= (db_reg[qpv_pkg::WIDE_W-1] == dc_reg[qpv_pkg::WIDE_W-1])
                                   && (db_reg != '0);
                        if (db_reg[qpv_pkg::WIDE_W-1]) begin
                            db_reg <= -db_reg;
                        end
                        if (dc_reg[qpv_pkg::WIDE_W-1]) begin
                            dc_reg <= -dc_reg;
                        end
                        state_reg <= S_NUM;
                    end
                end
                S_NUM: state_reg <= S_DIV;
                S_DIV: begin
                    if (div_done) begin
                        if (div_quo > lim) begin
                            res_pos_reg  <= neg_reg ? -qpv_pkg::VERT_W'(lim)
                                                    : qpv_pkg::VERT_W'(lim);
                            res_stat_reg <= qpv_pkg::ST_SAT;
                        end else begin
                            res_pos_reg  <= neg_reg ? -qpv_pkg::VERT_W'(div_quo)
                                                    : qpv_pkg::VERT_W'(div_quo);
                            res_stat_reg <= qpv_pkg::ST_OK;
                        end
                        state_reg <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (!m_valid_reg || m_ready) begin
                        out_pos_reg  <= res_pos_reg;
                        out_stat_reg <= res_stat_reg;
                        count_reg    <= '0;
                        sx_reg       <= '0;
                        sx2_reg      <= '0;
                        sx3_reg      <= '0;
                        sx4_reg      <= '0;
                        sy_reg       <= '0;
                        sxy_reg      <= '0;
                        sx2y_reg     <= '0;
                        state_reg    <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign s_ready = (state_reg == S_IDLE);
    assign m_valid = m_valid_reg;
    assign m_data  = {out_pos_reg, out_stat_reg};

    a_stat_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_data.fit_status <= qpv_pkg::ST_SAT))
        else $error("fit status out of range");

    a_degen_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_data.fit_status == qpv_pkg::ST_DEGEN) |-> (m_data.vertex_position == '0))
        else $error("degenerate fit with nonzero vertex");

    a_count_max: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= qpv_pkg::COUNT_W'(qpv_pkg::MAX_POINTS))
        else $error("point count past limit");

    a_div_start: assert property (@(posedge aclk) disable iff (!aresetn)
        div_done |-> $past(state_reg == S_DIV))
        else $error("divider finished outside the divide step");

endmodule

`default_nettype wire

// ----- dv/tb_quadratic_peak_vertex_fit.sv -----
// ----------------------------------------------------------------------------
// tb_quadratic_peak_vertex_fit
// Self-checking testbench for the least squares parabola vertex fit.
//
// A driver feeds peak points from a queue, and a shadow fit computes the
// expected vertex and status for each set of points. A monitor compares
// every result word against the oldest expected word. Both sides idle at
// random, and the receiver holds off once for a long stretch. The sender
// also pauses before some sets of points until all expected results have drained.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_quadratic_peak_vertex_fit;

    typedef logic signed [qpv_pkg::WIDE_W-1:0] swide_t;

    logic               aclk = 1'b0;
    logic               aresetn = 1'b0;
    logic               s_valid = 1'b0;
    logic               s_ready;
    qpv_pkg::in_word_t  s_data = '0;
    logic               m_valid;
    logic               m_ready = 1'b0;
    qpv_pkg::out_word_t m_data;

    quadratic_peak_vertex_fit dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    always #1 aclk = ~aclk;

    qpv_pkg::in_word_t  point_q [$];
    bit                 drain_q [$];
    qpv_pkg::out_word_t vertex_q [$];

    int     pt_count;
    longint acc_x, acc_x2, acc_x3, acc_x4, acc_y, acc_xy, acc_x2y;

    int  send_gap, recv_gap, hold_cycles;
    bit  fast_mode, hold_done;
    int  points_sent, fits_seen, mismatches, n_degen, n_sat, n_ok;

    function automatic qpv_pkg::out_word_t fit_vertex();
        swide_t             n, sx, sx2, sx3, sx4, sy, sxy, sx2y, db, dc;
        qpv_pkg::wide_t     adb, adc, num, den, q, lim;
        bit                 neg;
        qpv_pkg::out_word_t r;
        r.vertex_position = '0;
        r.fit_status = qpv_pkg::ST_DEGEN;
        if (pt_count < 3) return r;
        n = swide_t'(pt_count); sx = swide_t'(acc_x); sx2 = swide_t'(acc_x2);
        sx3 = swide_t'(acc_x3); sx4 = swide_t'(acc_x4);
        sy = swide_t'(acc_y); sxy = swide_t'(acc_xy); sx2y = swide_t'(acc_x2y);
        db = n * (sxy * sx4 - sx3 * sx2y) - sy * (sx * sx4 - sx3 * sx2)
           + sx2 * (sx * sx2y - sxy * sx2);
        dc = n * (sx2 * sx2y - sxy * sx3) - sx * (sx * sx2y - sxy * sx2)
           + sy * (sx * sx3 - sx2 * sx2);
        if (dc == 0) return r;
        neg = (db < 0) == (dc < 0);
        if (db == 0) neg = 1'b0;
        adb = (db < 0) ? -db : db;
        adc = (dc < 0) ? -dc : dc;
        num = (adb << (qpv_pkg::FRACTION_BITS + 1)) + (adc << 1);
        den = adc << 2;
        q = num / den;
        lim = qpv_pkg::WIDE_W'(neg ? qpv_pkg::VMAX_NEG : qpv_pkg::VMAX_POS);
        if (q > lim) begin
            q = lim;
            r.fit_status = qpv_pkg::ST_SAT;
        end else begin
            r.fit_status = qpv_pkg::ST_OK;
        end
        r.vertex_position = neg ? -q[qpv_pkg::VERT_W-1:0] : q[qpv_pkg::VERT_W-1:0];
        return r;
    endfunction

    task automatic take_point(qpv_pkg::in_word_t w);
        longint x, y;
        x = longint'(w.peak_position[qpv_pkg::POSITION_BITS-1:0]);
        y = longint'(w.peak_amplitude);
        if (pt_count < qpv_pkg::MAX_POINTS) begin
            pt_count++;
            acc_x += x; acc_x2 += x * x; acc_x3 += x * x * x; acc_x4 += x * x * x * x;
            acc_y += y; acc_xy += x * y; acc_x2y += x * x * y;
        end
        if (w.last_point) begin
            vertex_q.push_back(fit_vertex());
            pt_count = 0;
            acc_x = 0; acc_x2 = 0; acc_x3 = 0; acc_x4 = 0;
            acc_y = 0; acc_xy = 0; acc_x2y = 0;
        end
    endtask

    task automatic add_point(int pos, int amp, bit last, bit drain = 1'b0);
        qpv_pkg::in_word_t w;
        w.peak_position = qpv_pkg::POS_W'(pos);
        w.peak_amplitude = qpv_pkg::AMP_W'(amp);
        w.last_point = last;
        point_q.push_back(w);
        drain_q.push_back(drain);
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
            send_gap <= 0;
        end else begin
            if (s_valid && s_ready) begin
                take_point(s_data);
                points_sent++;
            end
            if (!(s_valid && !s_ready)) begin
                if (send_gap > 0) begin
                    send_gap <= send_gap - 1;
                    s_valid <= 1'b0;
                end else if (point_q.size() > 0 && !(drain_q[0] && vertex_q.size() > 0)) begin
                    s_data <= point_q.pop_front();
                    void'(drain_q.pop_front());
                    s_valid <= 1'b1;
                    send_gap <= fast_mode ? 0 : $urandom_range(0, 16);
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
            recv_gap <= 0;
            hold_cycles <= 0;
        end else begin
            if (m_valid && m_ready) begin
                fits_seen++;
                if (vertex_q.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("Unexpected result word: vertex %0d status %0d",
                                 m_data.vertex_position, m_data.fit_status);
                end else begin
                    if (m_data !== vertex_q[0]) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("Mismatch: vertex exp %0d act %0d, status exp %0d act %0d",
                                     vertex_q[0].vertex_position, m_data.vertex_position,
                                     vertex_q[0].fit_status, m_data.fit_status);
                    end
                    case (vertex_q[0].fit_status)
                        qpv_pkg::ST_OK:    n_ok++;
                        qpv_pkg::ST_DEGEN: n_degen++;
                        default:           n_sat++;
                    endcase
                    void'(vertex_q.pop_front());
                end
                if ($urandom_range(0, 9) == 0) fast_mode = ~fast_mode;
            end
            if (hold_cycles > 0) begin
                hold_cycles <= hold_cycles - 1;
                m_ready <= 1'b0;
            end else if (!hold_done && fits_seen == 25) begin
                hold_done <= 1'b1;
                hold_cycles <= 5000;
                m_ready <= 1'b0;
            end else if (m_valid && m_ready) begin
                recv_gap <= fast_mode ? 0 : $urandom_range(0, 16);
                m_ready <= fast_mode || ($urandom_range(0, 1) == 0);
            end else if (recv_gap > 0) begin
                recv_gap <= recv_gap - 1;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    initial begin
        int total, k, len, kind, p0, c;
        // Exact parabola, negative parabola, too few points, one position only.
        add_point(10, 100, 0); add_point(20, 400, 0); add_point(30, 100, 1);
        add_point(0, -32768, 0); add_point(4095, 32767, 0); add_point(2048, -32768, 1);
        add_point(4095, 32767, 1);
        add_point(5, 7, 0); add_point(6, -7, 1);
        add_point(100, 1, 0); add_point(100, 50, 0); add_point(100, -9, 1);
        // Nearly straight line, so the vertex runs far out.
        add_point(0, 0, 0); add_point(1, 10000, 0); add_point(2, 20001, 1);
        add_point(0, 0, 0); add_point(1, -10000, 0); add_point(2, -19999, 1);
        // Flat amplitude gives a zero vertex.
        add_point(0, 5, 0); add_point(7, 5, 0); add_point(4095, 5, 1, 1'b1);
        // More points than the block keeps.
        for (k = 0; k < 70; k++) add_point($urandom_range(0, 4095),
                                           $urandom_range(0, 65535), k == 69);
        total = 0;
        while (total < 700) begin
            kind = $urandom_range(0, 19);
            len = (kind == 0) ? $urandom_range(1, 2) :
                  (kind == 1) ? $urandom_range(60, 72) : $urandom_range(3, 10);
            p0 = $urandom_range(0, 4095);
            c = $urandom_range(1, 40);
            for (k = 0; k < len; k++) begin
                if (kind < 10) begin
                    int x, dx;
                    x = (p0 + $urandom_range(0, 60)) % 4096;
                    dx = x - p0 - 30;
                    add_point(x, 30000 - c * dx * dx / 8 + $urandom_range(0, 200) - 100,
                              k == len - 1, total > 350 && total < 360 && k == 0);
                end else begin
                    add_point($urandom_range(0, 4095), $urandom_range(0, 65535),
                              k == len - 1 || $urandom_range(0, 199) == 0);
                end
                total++;
            end
        end
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        wait (point_q.size() == 0 && !(s_valid && !s_ready));
        @(posedge aclk);
        wait (vertex_q.size() == 0);
        repeat (1000) @(posedge aclk);
        $display("Sent %0d points and checked %0d fits: %0d ok, %0d degenerate, %0d saturated.",
                 points_sent, fits_seen, n_ok, n_degen, n_sat);
        if (mismatches == 0 && vertex_q.size() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("%0d mismatches, %0d results missing", mismatches, vertex_q.size());
            $display("RESULT: ERROR");
        end
        $finish;
    end

    initial begin
        #4000000;
        $display("Timeout with %0d results outstanding", vertex_q.size());
        $display("RESULT: ERROR");
        $finish;
    end

endmodule

`default_nettype wire

// ----- sim.f -----
src/qpv_pkg.sv
src/qpv_mul.sv
src/qpv_div.sv
src/quadratic_peak_vertex_fit.sv
dv/tb_quadratic_peak_vertex_fit.sv
